// ===== rtl/stsi_pkg.sv =====
// Package for the slot table with scan iterator.
// Holds the command and status codes, the stored entry and result types, and
// width helpers. No dependencies.
`timescale 1ns / 1ps

package stsi_pkg;

  // Default number of slots and fixed field widths
  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OUT_IDX_W = 5;

  // Address width for a store of the given depth (at least one bit)
  function automatic int unsigned addr_w(input int unsigned slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

  // Width of a counter that must also hold the depth itself
  function automatic int unsigned idx_w(input int unsigned slots);
    return $clog2(slots + 1);
  endfunction

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_BEGIN  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_AT_END    = 3'd3,
    ST_END       = 3'd4
  } status_e;

  // One stored slot
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Result of one transaction, apart from the index fields
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] payload;
  } res_t;

  // Request to the shared compare unit
  typedef struct packed {
    logic [DATA_W-1:0] ref_key;
    logic              want_occupied;
  } step_req_t;

  // Answer from the shared compare unit
  typedef struct packed {
    logic at_limit;
    logic hit;
  } step_rsp_t;

endpackage

// ===== rtl/stsi_store.sv =====
// Slot store: one write port and one registered read port.
// Depends on stsi_pkg for the entry type and address width.
`timescale 1ns / 1ps

module stsi_store #(
  parameter int unsigned SLOTS = stsi_pkg::SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [stsi_pkg::addr_w(SLOTS)-1:0]    waddr_i,
  input  stsi_pkg::entry_t                      wdata_i,
  input  logic [stsi_pkg::addr_w(SLOTS)-1:0]    raddr_i,
  output stsi_pkg::entry_t                      rdata_o
);
  import stsi_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stsi_step.sv =====
// Shared scan unit: limit compare, key compare and pointer increment.
// Depends on stsi_pkg for the request and answer types.
`timescale 1ns / 1ps

module stsi_step #(
  parameter int unsigned SLOTS = stsi_pkg::SLOTS_DEF
) (
  input  logic [stsi_pkg::idx_w(SLOTS)-1:0]  ptr_i,
  input  logic [stsi_pkg::idx_w(SLOTS)-1:0]  limit_i,
  input  logic [stsi_pkg::DATA_W-1:0]        rd_key_i,
  input  stsi_pkg::step_req_t                req_i,
  output stsi_pkg::step_rsp_t                rsp_o,
  output logic [stsi_pkg::idx_w(SLOTS)-1:0]  ptr_inc_o
);
  import stsi_pkg::*;

  localparam int unsigned IW = idx_w(SLOTS);

  // Pointer has run to the end of the range being scanned
  assign rsp_o.at_limit = (ptr_i >= limit_i);

  // Either looking for any occupied slot or for an exact key
  assign rsp_o.hit = req_i.want_occupied ? (rd_key_i != '0)
                                         : (rd_key_i == req_i.ref_key);

  assign ptr_inc_o = ptr_i + IW'(1);

endmodule

// ===== rtl/stsi_ctrl.sv =====
// Sequencer for the slot table: clearing pass, insert, erase with mark trim,
// begin and next. Drives the slot store and the shared scan unit.
// Depends on stsi_pkg.
`timescale 1ns / 1ps

module stsi_ctrl #(
  parameter int unsigned SLOTS = stsi_pkg::SLOTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command side
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  stsi_pkg::cmd_e                        cmd_i,
  input  logic [stsi_pkg::DATA_W-1:0]           key_i,
  input  logic [stsi_pkg::DATA_W-1:0]           payload_i,
  // result side
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output stsi_pkg::res_t                        res_o,
  output logic [stsi_pkg::idx_w(SLOTS)-1:0]     res_index_o,
  output logic [stsi_pkg::idx_w(SLOTS)-1:0]     res_mark_o,
  // slot store
  output logic                                  we_o,
  output logic [stsi_pkg::addr_w(SLOTS)-1:0]    waddr_o,
  output stsi_pkg::entry_t                      wdata_o,
  output logic [stsi_pkg::addr_w(SLOTS)-1:0]    raddr_o,
  input  stsi_pkg::entry_t                      rdata_i,
  // shared scan unit
  output logic [stsi_pkg::idx_w(SLOTS)-1:0]     ptr_o,
  output logic [stsi_pkg::idx_w(SLOTS)-1:0]     limit_o,
  output stsi_pkg::step_req_t                   step_req_o,
  input  stsi_pkg::step_rsp_t                   step_rsp_i,
  input  logic [stsi_pkg::idx_w(SLOTS)-1:0]     ptr_inc_i
);
  import stsi_pkg::*;

  localparam int unsigned AW = addr_w(SLOTS);
  localparam int unsigned IW = idx_w(SLOTS);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_RD       = 7'b0000100,
    S_CMP      = 7'b0001000,
    S_TRIM_RD  = 7'b0010000,
    S_TRIM_CMP = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        ptr_q, ptr_d;
  logic [IW-1:0]        mark_q, mark_d;
  logic [IW-1:0]        cursor_q, cursor_d;
  cmd_e                 cmd_q, cmd_d;
  logic [DATA_W-1:0]    key_q, key_d;
  logic [DATA_W-1:0]    pay_q, pay_d;
  res_t                 res_q, res_d;
  logic [IW-1:0]        res_idx_q, res_idx_d;

  logic [IW-1:0]        mark_dec;
  logic [IW-1:0]        cursor_inc;
  logic                 scan_iter;

  assign mark_dec   = mark_q - IW'(1);
  assign cursor_inc = cursor_q + IW'(1);
  assign scan_iter  = (cmd_q == CMD_BEGIN) || (cmd_q == CMD_NEXT);

  // Shared scan unit hookup
  assign ptr_o   = ptr_q;
  assign limit_o = (cmd_q == CMD_INSERT) ? IW'(SLOTS) : mark_q;
  assign step_req_o.want_occupied = scan_iter;
  assign step_req_o.ref_key = ((state_q == S_CMP) && (cmd_q == CMD_ERASE)) ? key_q : '0;

  // Read address: trim walks down from the mark, everything else follows ptr
  assign raddr_o = (state_q == S_TRIM_RD) ? mark_dec[AW-1:0] : ptr_q[AW-1:0];
  assign waddr_o = ptr_q[AW-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign res_index_o = res_idx_q;
  assign res_mark_o  = mark_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    mark_d    = mark_q;
    cursor_d  = cursor_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    pay_d     = pay_q;
    res_d     = res_q;
    res_idx_d = res_idx_q;
    we_o      = 1'b0;
    wdata_o   = '0;

    case (state_q)
      // Zero the slots one after another, from slot 0 up, after reset
      S_CLEAR: begin
        we_o = 1'b1;
        if (ptr_q == IW'(SLOTS - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_inc_i;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          key_d       = key_i;
          pay_d       = payload_i;
          res_d       = '0;
          res_idx_d   = '0;
          ptr_d       = '0;
          state_d     = S_RD;
          if (cmd_i == CMD_NEXT) begin
            if (cursor_q >= mark_q) begin
              res_d.status = ST_AT_END;
              res_idx_d    = mark_q;
              state_d      = S_DONE;
            end else begin
              ptr_d = cursor_inc;
            end
          end
        end
      end

      // Range check, read of the slot under ptr in flight
      S_RD: begin
        if (step_rsp_i.at_limit) begin
          state_d = S_DONE;
          case (cmd_q)
            CMD_INSERT: res_d.status = ST_FULL;
            CMD_ERASE:  res_d.status = ST_NOT_FOUND;
            default: begin
              res_d.status = ST_END;
              res_idx_d    = mark_q;
              cursor_d     = ptr_q;
            end
          endcase
        end else begin
          state_d = S_CMP;
        end
      end

      // Compare the slot just read
      S_CMP: begin
        if (step_rsp_i.hit) begin
          res_d.status = ST_OK;
          res_idx_d    = ptr_q;
          case (cmd_q)
            CMD_INSERT: begin
              we_o         = 1'b1;
              wdata_o.key  = key_q;
              wdata_o.data = pay_q;
              if (ptr_q >= mark_q) begin
                mark_d = ptr_inc_i;
              end
              state_d = S_DONE;
            end
            CMD_ERASE: begin
              we_o    = 1'b1;
              state_d = S_TRIM_RD;
            end
            default: begin
              res_d.key     = rdata_i.key;
              res_d.payload = rdata_i.data;
              cursor_d      = ptr_q;
              state_d       = S_DONE;
            end
          endcase
        end else begin
          ptr_d   = ptr_inc_i;
          state_d = S_RD;
        end
      end

      // Pull the mark down past trailing empty slots
      S_TRIM_RD: begin
        state_d = (mark_q == '0) ? S_DONE : S_TRIM_CMP;
      end

      S_TRIM_CMP: begin
        if (step_rsp_i.hit) begin
          mark_d  = mark_dec;
          state_d = S_TRIM_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ptr_q    <= '0;
      mark_q   <= '0;
      cursor_q <= '0;
      cmd_q    <= CMD_INSERT;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      mark_q   <= mark_d;
      cursor_q <= cursor_d;
      cmd_q    <= cmd_d;
    end
  end

  // Operands and result, no reset needed
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    pay_q     <= pay_d;
    res_q     <= res_d;
    res_idx_q <= res_idx_d;
  end

  // The mark never passes the table size
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= IW'(SLOTS))
    else $error("mark beyond table size");

  // Store is only written while clearing or on a hit
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q == S_CLEAR || state_q == S_CMP))
    else $error("store written outside clear or compare");

  // A held result is not dropped
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE))
    else $error("result left before it was taken");

  // Trim only follows an erase
  a_trim_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIM_RD || state_q == S_TRIM_CMP) |-> (cmd_q == CMD_ERASE))
    else $error("trim outside erase");

endmodule

// ===== rtl/slot_table_with_scan_iterator.sv =====
// Slot table with first-free insert, erase by key and a scanning iterator.
// Top level: sequencer, slot store, shared scan unit and output register.
// Depends on stsi_pkg, stsi_store, stsi_step and stsi_ctrl.
//
// One transaction at a time. The table is scanned one slot at a time
// through the single registered read port of the slot store: each slot is
// read, then compared. An erase that hits then trims the high-water mark
// past the empty slots below it. After reset a clearing pass zeroes the
// store, one slot per cycle, during which in_ready_o stays low. A finished
// result sits in an output register, so the next transaction is taken
// while it waits.
`timescale 1ns / 1ps

module slot_table_with_scan_iterator #(
  parameter int unsigned SLOTS = stsi_pkg::SLOTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             cmd_i,
  input  logic [stsi_pkg::DATA_W-1:0]            key_id_i,
  input  logic [stsi_pkg::DATA_W-1:0]            record_payload_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0]                             status_o,
  output logic [stsi_pkg::OUT_IDX_W-1:0]         slot_index_o,
  output logic [stsi_pkg::DATA_W-1:0]            out_key_o,
  output logic [stsi_pkg::DATA_W-1:0]            out_payload_o,
  output logic [stsi_pkg::OUT_IDX_W-1:0]         high_water_o
);
  import stsi_pkg::*;

  localparam int unsigned AW = addr_w(SLOTS);
  localparam int unsigned IW = idx_w(SLOTS);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic [IW-1:0]     res_index;
  logic [IW-1:0]     res_mark;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  entry_t            wdata;
  entry_t            rdata;
  logic [IW-1:0]     ptr;
  logic [IW-1:0]     limit;
  logic [IW-1:0]     ptr_inc;
  step_req_t         step_req;
  step_rsp_t         step_rsp;

  logic [31:0]       index_wide;
  logic [31:0]       mark_wide;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q;
  logic [OUT_IDX_W-1:0] slot_index_q;
  logic [DATA_W-1:0] out_key_q;
  logic [DATA_W-1:0] out_payload_q;
  logic [OUT_IDX_W-1:0] high_water_q;

  stsi_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_e'(cmd_i)),
    .key_i       (key_id_i),
    .payload_i   (record_payload_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_index_o (res_index),
    .res_mark_o  (res_mark),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .ptr_o       (ptr),
    .limit_o     (limit),
    .step_req_o  (step_req),
    .step_rsp_i  (step_rsp),
    .ptr_inc_i   (ptr_inc)
  );

  stsi_store #(.SLOTS(SLOTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stsi_step #(.SLOTS(SLOTS)) u_step (
    .ptr_i     (ptr),
    .limit_i   (limit),
    .rd_key_i  (rdata.key),
    .req_i     (step_req),
    .rsp_o     (step_rsp),
    .ptr_inc_o (ptr_inc)
  );

  // Index fields carry the low bits of the internal counters
  assign index_wide = 32'(res_index);
  assign mark_wide  = 32'(res_mark);

  // Output register: refill when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q      <= res.status;
      slot_index_q  <= index_wide[OUT_IDX_W-1:0];
      out_key_q     <= res.key;
      out_payload_q <= res.payload;
      high_water_q  <= mark_wide[OUT_IDX_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_index_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_payload_q;
  assign high_water_o  = high_water_q;

endmodule
